/* src/nfci_pkg.sv */
// Types and constants shared by the NOR flash command interface modules.
package nfci_pkg;

  localparam int unsigned DATA_W = 16;

  localparam logic [DATA_W-1:0] ERASED_WORD = 16'hFFFF;

  // Command bytes (low byte of the write word)
  localparam logic [7:0] CMD_READ_ARRAY   = 8'hFF;
  localparam logic [7:0] CMD_READ_ID      = 8'h90;
  localparam logic [7:0] CMD_READ_STATUS  = 8'h70;
  localparam logic [7:0] CMD_CLEAR_STATUS = 8'h50;
  localparam logic [7:0] CMD_PROG_SETUP   = 8'h40;
  localparam logic [7:0] CMD_ERASE_SETUP  = 8'h20;
  localparam logic [7:0] CMD_LOCK_SETUP   = 8'h60;
  localparam logic [7:0] CMD_CONFIRM      = 8'hD0;
  localparam logic [7:0] CMD_LOCK_BLOCK   = 8'h01;

  // Error bit positions
  localparam int unsigned ERR_LOCK  = 0;
  localparam int unsigned ERR_PROG  = 1;
  localparam int unsigned ERR_ERASE = 2;

  // Status word: ready bit plus error flags
  localparam logic [DATA_W-1:0] STATUS_READY = 16'h0080;

  // ID space offsets within a block
  localparam int unsigned ID_OFF_MFR  = 0;
  localparam int unsigned ID_OFF_DEV  = 1;
  localparam int unsigned ID_OFF_LOCK = 2;

  // Configuration register indexes
  localparam logic REG_MFR = 1'b0;
  localparam logic REG_DEV = 1'b1;

  typedef enum logic [1:0] {
    MODE_ARRAY  = 2'd0,
    MODE_ID     = 2'd1,
    MODE_STATUS = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    SETUP_NONE    = 2'd0,
    SETUP_PROGRAM = 2'd1,
    SETUP_ERASE   = 2'd2,
    SETUP_LOCK    = 2'd3
  } setup_e;

  typedef enum logic [1:0] {
    ST_CLEAR = 2'd0,
    ST_IDLE  = 2'd1,
    ST_EXEC  = 2'd2,
    ST_ERASE = 2'd3
  } state_e;

  typedef struct packed {
    logic              req_type;
    logic [DATA_W-1:0] word_address;
    logic [DATA_W-1:0] write_data;
  } nfci_in_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic              was_read;
  } nfci_out_t;

endpackage

/* src/nfci_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module nfci_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned AW    = 8
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [2**AW];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, data holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* src/nor_flash_command_interface_top.sv */
// NOR flash command interface: command decoder over array and lock-bit RAMs.
//
//  channel | direction | handshake               | word
//  --------+-----------+-------------------------+------------------------------
//  in      | input     | in_valid_i/in_stall_o   | nfci_in_t  (read or write)
//  out     | output    | out_valid_o/out_stall_i | nfci_out_t (one per access)
//  cfg     | input     | APB psel/penable        | ID codes, 32-bit data
//
// An access is accepted in idle: the accept edge reads the array and lock RAMs,
// and the commit in execute writes the update and loads the output register.
// A confirmed erase then walks its block one word per cycle, 2**BLOCK_BITS
// words (capped at the array size); a stalled output holds the commit.
// After reset a clearing pass erases every word and locks every block; the
// input stays stalled during both walks.
module nor_flash_command_interface_top
  import nfci_pkg::*;
#(
  parameter int unsigned ADDR_BITS  = 16,
  parameter int unsigned BLOCK_BITS = 12
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // access channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  nfci_in_t    in_word_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output nfci_out_t   out_word_o,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // offset bits within a block, block index bits
  localparam int unsigned OB      = (BLOCK_BITS < ADDR_BITS) ? BLOCK_BITS : ADDR_BITS;
  localparam int unsigned IB      = ADDR_BITS - OB;
  localparam int unsigned LOCK_AW = (IB > 0) ? IB : 1;

  state_e state_q, state_d;
  mode_e  mode_q, mode_d;
  setup_e setup_q, setup_d;
  logic [2:0] err_q, err_d;
  logic [DATA_W-1:0] mfr_q, dev_q;
  logic [ADDR_BITS-1:0] cnt_q, cnt_d;

  nfci_in_t             item_q;
  logic [ADDR_BITS-1:0] addr_q;
  logic [LOCK_AW-1:0]   blk_q;
  nfci_out_t            out_q, out_d;
  logic                 out_valid_q, out_valid_d;

  logic [ADDR_BITS-1:0] in_addr, erase_addr;
  logic [LOCK_AW-1:0]   in_blk;
  logic                 accept, out_free, commit;
  logic [DATA_W-1:0]    arr_rd;
  logic                 lock_rd;
  logic [7:0]           cmd;
  logic [OB-1:0]        off;
  logic [DATA_W-1:0]    status_word;
  logic                 erase_go;

  logic                 arr_we;
  logic [ADDR_BITS-1:0] arr_waddr;
  logic [DATA_W-1:0]    arr_wdata;
  logic                 lock_we;
  logic [LOCK_AW-1:0]   lock_waddr;
  logic                 lock_wdata;

  // address split into block index and erase address
  assign in_addr = ADDR_BITS'(in_word_i.word_address);

  if (IB > 0) begin : g_blocks
    assign in_blk     = in_addr[ADDR_BITS-1:OB];
    assign erase_addr = {blk_q, cnt_q[OB-1:0]};
  end else begin : g_one_block
    assign in_blk     = '0;
    assign erase_addr = cnt_q[OB-1:0];
  end

  assign accept   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign commit   = (state_q == ST_EXEC) && out_free;
  assign cmd      = item_q.write_data[7:0];
  assign off      = addr_q[OB-1:0];

  assign status_word = STATUS_READY
                     | (DATA_W'(err_q[ERR_ERASE]) << 5)
                     | (DATA_W'(err_q[ERR_PROG]) << 4)
                     | (DATA_W'(err_q[ERR_LOCK]) << 1);

  assign erase_go = item_q.req_type && (setup_q == SETUP_ERASE)
                 && (cmd == CMD_CONFIRM) && !lock_rd;

  // state memories
  nfci_ram #(.WIDTH(DATA_W), .AW(ADDR_BITS)) u_array_ram (
    .clk_i   (clk_i),
    .we_i    (arr_we),
    .waddr_i (arr_waddr),
    .wdata_i (arr_wdata),
    .re_i    (accept),
    .raddr_i (in_addr),
    .rdata_o (arr_rd)
  );

  nfci_ram #(.WIDTH(1), .AW(LOCK_AW)) u_lock_ram (
    .clk_i   (clk_i),
    .we_i    (lock_we),
    .waddr_i (lock_waddr),
    .wdata_i (lock_wdata),
    .re_i    (accept),
    .raddr_i (in_blk),
    .rdata_o (lock_rd)
  );

  // sequencer next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: if (&cnt_q) state_d = ST_IDLE;
      ST_IDLE:  if (in_valid_i) state_d = ST_EXEC;
      ST_EXEC: begin
        if (out_free) state_d = erase_go ? ST_ERASE : ST_IDLE;
      end
      ST_ERASE: if (&cnt_q[OB-1:0]) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs: RAM writes, counter, handshake
  always_comb begin
    in_stall_o = (state_q != ST_IDLE);
    cnt_d      = cnt_q;
    arr_we     = 1'b0;
    arr_waddr  = addr_q;
    arr_wdata  = arr_rd & item_q.write_data;
    lock_we    = 1'b0;
    lock_waddr = blk_q;
    lock_wdata = (cmd == CMD_LOCK_BLOCK);
    unique case (state_q)
      ST_CLEAR: begin
        cnt_d      = cnt_q + 1'b1;
        arr_we     = 1'b1;
        arr_waddr  = cnt_q;
        arr_wdata  = ERASED_WORD;
        lock_we    = 1'b1;
        lock_waddr = cnt_q[LOCK_AW-1:0];
        lock_wdata = 1'b1;
      end
      ST_EXEC: begin
        if (commit && item_q.req_type) begin
          arr_we  = (setup_q == SETUP_PROGRAM) && !lock_rd;
          lock_we = (setup_q == SETUP_LOCK)
                 && ((cmd == CMD_CONFIRM) || (cmd == CMD_LOCK_BLOCK));
        end
        if (commit && erase_go) cnt_d = '0;
      end
      ST_ERASE: begin
        cnt_d     = cnt_q + 1'b1;
        arr_we    = 1'b1;
        arr_waddr = erase_addr;
        arr_wdata = ERASED_WORD;
      end
      default: ;
    endcase
  end

  // command decode and result formation
  always_comb begin
    mode_d      = mode_q;
    setup_d     = setup_q;
    err_d       = err_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (commit) begin
      out_valid_d = 1'b1;
      out_d       = '0;
      if (!item_q.req_type) begin
        out_d.was_read = 1'b1;
        unique case (mode_q)
          MODE_STATUS: out_d.read_data = status_word;
          MODE_ID: begin
            if (off == OB'(ID_OFF_MFR))       out_d.read_data = mfr_q;
            else if (off == OB'(ID_OFF_DEV))  out_d.read_data = dev_q;
            else if (off == OB'(ID_OFF_LOCK)) out_d.read_data = DATA_W'(lock_rd);
            else                              out_d.read_data = '0;
          end
          MODE_ARRAY: out_d.read_data = arr_rd;
          default:    out_d.read_data = '0;
        endcase
      end else if (setup_q != SETUP_NONE) begin
        // second write of a two-write setup sequence
        unique case (setup_q)
          SETUP_PROGRAM: begin
            if (lock_rd) begin
              err_d[ERR_LOCK] = 1'b1;
              err_d[ERR_PROG] = 1'b1;
            end
          end
          SETUP_ERASE: begin
            if (cmd != CMD_CONFIRM) begin
              err_d[ERR_PROG]  = 1'b1;
              err_d[ERR_ERASE] = 1'b1;
            end else if (lock_rd) begin
              err_d[ERR_LOCK]  = 1'b1;
              err_d[ERR_ERASE] = 1'b1;
            end
          end
          default: begin
            if ((cmd != CMD_CONFIRM) && (cmd != CMD_LOCK_BLOCK)) begin
              err_d[ERR_PROG]  = 1'b1;
              err_d[ERR_ERASE] = 1'b1;
            end
          end
        endcase
        setup_d = SETUP_NONE;
        mode_d  = MODE_STATUS;
      end else begin
        unique case (cmd)
          CMD_READ_ARRAY:   mode_d = MODE_ARRAY;
          CMD_READ_ID:      mode_d = MODE_ID;
          CMD_READ_STATUS:  mode_d = MODE_STATUS;
          CMD_CLEAR_STATUS: err_d  = '0;
          CMD_PROG_SETUP: begin
            setup_d = SETUP_PROGRAM;
            mode_d  = MODE_STATUS;
          end
          CMD_ERASE_SETUP: begin
            setup_d = SETUP_ERASE;
            mode_d  = MODE_STATUS;
          end
          CMD_LOCK_SETUP: begin
            setup_d = SETUP_LOCK;
            mode_d  = MODE_STATUS;
          end
          default: ;
        endcase
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      mode_q      <= MODE_ARRAY;
      setup_q     <= SETUP_NONE;
      err_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      setup_q     <= setup_d;
      err_q       <= err_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // accepted word and output payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_word_i;
      addr_q <= in_addr;
      blk_q  <= in_blk;
    end
    out_q <= out_d;
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mfr_q <= 16'd137;
      dev_q <= 16'd0;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_MFR) mfr_q <= pwdata[DATA_W-1:0];
      else                     dev_q <= pwdata[DATA_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_DEV) ? 32'(dev_q) : 32'(mfr_q);
  assign pready = 1'b1;

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

`ifndef ASSERT_OFF
  // an accepted access enters execute
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_EXEC))
    else $error("accepted access did not enter execute");

  // a blocked output keeps the access in execute
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EXEC && out_valid_q && out_stall_i) |=> (state_q == ST_EXEC))
    else $error("access left execute while output was full");

  // no array write while waiting for an access
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !arr_we)
    else $error("array written while idle");

  // a pending setup always reads in status mode
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (setup_q != SETUP_NONE) |-> (mode_q == MODE_STATUS))
    else $error("setup pending outside status mode");

  // erase walk starts at offset zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EXEC && state_d == ST_ERASE) |=> (cnt_q[OB-1:0] == '0))
    else $error("erase walk did not start at block base");
`endif

endmodule

/* dv/nor_flash_command_interface_top_tb.sv */
// Testbench for the NOR flash command interface: shadow flash model and response checker.
module nor_flash_command_interface_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import nfci_pkg::*;

  localparam int unsigned ADDR_BITS   = 16;
  localparam int unsigned BLOCK_BITS  = 12;
  localparam int unsigned NUM_WORDS   = 1 << ADDR_BITS;
  localparam int unsigned BLOCK_WORDS = 1 << BLOCK_BITS;
  localparam int unsigned NUM_BLOCKS  = 1 << (ADDR_BITS - BLOCK_BITS);
  // clearing pass after reset is the longest quiet stretch
  localparam int unsigned WATCHDOG_LIMIT = 4 * NUM_WORDS;
  // an erase walk may still run after its response has left
  localparam int unsigned ERASE_SETTLE   = BLOCK_WORDS + 100;
  localparam int unsigned MAX_REPORTS    = 10;
  // status register flag positions
  localparam int unsigned SR_LOCK_BIT  = 1;
  localparam int unsigned SR_PROG_BIT  = 4;
  localparam int unsigned SR_ERASE_BIT = 5;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  nfci_in_t    in_word_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  nfci_out_t   out_word_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // shadow copy of the device state
  logic [DATA_W-1:0]     shadow_array [NUM_WORDS];
  logic [NUM_BLOCKS-1:0] shadow_locked;
  mode_e                 shadow_mode;
  setup_e                shadow_setup;
  logic [2:0]            shadow_err;
  logic [DATA_W-1:0]     shadow_mfr;
  logic [DATA_W-1:0]     shadow_dev;

  nfci_out_t   due_responses [$];
  int unsigned mismatches = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned quiet_cycles = 0;

  always #1 clk_i = ~clk_i;

  nor_flash_command_interface_top #(
    .ADDR_BITS (ADDR_BITS),
    .BLOCK_BITS(BLOCK_BITS)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o (out_word_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  task automatic shadow_reset();
    int unsigned i;
    for (i = 0; i < NUM_WORDS; i++) shadow_array[i] = ERASED_WORD;
    shadow_locked = '1;
    shadow_mode   = MODE_ARRAY;
    shadow_setup  = SETUP_NONE;
    shadow_err    = '0;
    shadow_mfr    = DATA_W'(137);
    shadow_dev    = '0;
  endtask

  function automatic logic [DATA_W-1:0] status_word();
    logic [DATA_W-1:0] s;
    s = STATUS_READY;
    s[SR_LOCK_BIT]  = shadow_err[ERR_LOCK];
    s[SR_PROG_BIT]  = shadow_err[ERR_PROG];
    s[SR_ERASE_BIT] = shadow_err[ERR_ERASE];
    return s;
  endfunction

  // Apply one access to the shadow state and return the response it yields
  function automatic nfci_out_t flash_respond(nfci_in_t w);
    logic [ADDR_BITS-1:0]  a;
    logic [BLOCK_BITS-1:0] off;
    logic [7:0]            cmd;
    int unsigned           blk;
    int unsigned           base;
    int unsigned           i;
    nfci_out_t             r;
    a    = w.word_address[ADDR_BITS-1:0];
    off  = a[BLOCK_BITS-1:0];
    cmd  = w.write_data[7:0];
    blk  = a >> BLOCK_BITS;
    base = blk << BLOCK_BITS;
    r    = '0;
    if (!w.req_type) begin
      r.was_read = 1'b1;
      case (shadow_mode)
        MODE_STATUS: r.read_data = status_word();
        MODE_ID: begin
          if (off == ID_OFF_MFR) r.read_data = shadow_mfr;
          else if (off == ID_OFF_DEV) r.read_data = shadow_dev;
          else if (off == ID_OFF_LOCK) r.read_data = DATA_W'(shadow_locked[blk]);
          else r.read_data = '0;
        end
        default: r.read_data = shadow_array[a];
      endcase
      return r;
    end
    if (shadow_setup == SETUP_NONE) begin
      // plain command byte
      case (cmd)
        CMD_READ_ARRAY:   shadow_mode = MODE_ARRAY;
        CMD_READ_ID:      shadow_mode = MODE_ID;
        CMD_READ_STATUS:  shadow_mode = MODE_STATUS;
        CMD_CLEAR_STATUS: shadow_err = '0;
        CMD_PROG_SETUP: begin
          shadow_setup = SETUP_PROGRAM;
          shadow_mode  = MODE_STATUS;
        end
        CMD_ERASE_SETUP: begin
          shadow_setup = SETUP_ERASE;
          shadow_mode  = MODE_STATUS;
        end
        CMD_LOCK_SETUP: begin
          shadow_setup = SETUP_LOCK;
          shadow_mode  = MODE_STATUS;
        end
        default: ;
      endcase
      return r;
    end
    // second write of a setup sequence
    case (shadow_setup)
      SETUP_PROGRAM: begin
        if (shadow_locked[blk]) begin
          shadow_err[ERR_LOCK] = 1'b1;
          shadow_err[ERR_PROG] = 1'b1;
        end else begin
          shadow_array[a] = shadow_array[a] & w.write_data;
        end
      end
      SETUP_ERASE: begin
        if (cmd != CMD_CONFIRM) begin
          shadow_err[ERR_PROG]  = 1'b1;
          shadow_err[ERR_ERASE] = 1'b1;
        end else if (shadow_locked[blk]) begin
          shadow_err[ERR_LOCK]  = 1'b1;
          shadow_err[ERR_ERASE] = 1'b1;
        end else begin
          for (i = 0; i < BLOCK_WORDS; i++) shadow_array[base + i] = ERASED_WORD;
        end
      end
      default: begin
        if (cmd == CMD_CONFIRM) shadow_locked[blk] = 1'b0;
        else if (cmd == CMD_LOCK_BLOCK) shadow_locked[blk] = 1'b1;
        else begin
          shadow_err[ERR_PROG]  = 1'b1;
          shadow_err[ERR_ERASE] = 1'b1;
        end
      end
    endcase
    shadow_setup = SETUP_NONE;
    shadow_mode  = MODE_STATUS;
    return r;
  endfunction

  task automatic note_mismatch(string what, int unsigned want, int unsigned got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("%0t: mismatch in %s: expected %h, got %h", $realtime, what, want, got);
  endtask

  // Check responses against the oldest prediction, predict each accepted access
  always @(posedge clk_i) begin : scoreboard
    nfci_out_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (due_responses.size() == 0) begin
          note_mismatch("unexpected response word", 0, out_word_o);
        end else begin
          want = due_responses.pop_front();
          if (out_word_o.read_data !== want.read_data)
            note_mismatch("read_data", want.read_data, out_word_o.read_data);
          if (out_word_o.was_read !== want.was_read)
            note_mismatch("was_read", want.was_read, out_word_o.was_read);
        end
      end
      if (in_valid_i && !in_stall_o) due_responses.push_back(flash_respond(in_word_i));
    end
  end

  // Receiver back-pressure
  always @(posedge clk_i) out_stall_i <= ($urandom_range(99) < recv_idle_pct);

  // Watchdog: cycles without any accepted access, delivered response or register transfer
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (psel && penable && pready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("nor_flash_command_interface_top regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Send one access word; valid stays high on return
  task automatic send_access(logic req, logic [DATA_W-1:0] addr, logic [DATA_W-1:0] data);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_word_i  <= '{req_type: req, word_address: addr, write_data: data};
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic read_word(logic [DATA_W-1:0] addr);
    send_access(1'b0, addr, DATA_W'($urandom));
  endtask

  task automatic write_word(logic [DATA_W-1:0] addr, logic [DATA_W-1:0] data);
    send_access(1'b1, addr, data);
  endtask

  task automatic write_cmd(logic [7:0] cmd);
    write_word(DATA_W'($urandom), {8'($urandom), cmd});
  endtask

  // Drop valid and hold off until every predicted response has arrived
  task automatic settle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (due_responses.size() != 0);
  endtask

  // Register write, only while the access path is idle
  task automatic write_reg(logic idx, logic [DATA_W-1:0] value);
    repeat (ERASE_SETTLE) @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'($urandom), value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_MFR) shadow_mfr = value;
    else shadow_dev = value;
  endtask

  function automatic logic [DATA_W-1:0] pick_address();
    logic [DATA_W-1:0] a;
    a = DATA_W'($urandom);
    // bias toward the first few words of a block so ID and programmed data get read back
    if ($urandom_range(1)) a[BLOCK_BITS-1:0] = BLOCK_BITS'($urandom_range(7));
    return a;
  endfunction

  // Array and ID reads, status command, unknown command
  task automatic test_read_modes();
    read_word(16'h0000);
    read_word(16'hFFFF);
    write_word(16'h1234, {8'hFF, CMD_READ_ID});
    read_word(16'h0000);
    read_word(16'h3001);
    read_word(16'hF002);
    read_word(16'h5ABC);
    write_word(16'hFFFF, 16'h0000);
    read_word(16'hFFFF);
    write_cmd(CMD_READ_STATUS);
    read_word(16'h0000);
  endtask

  // Program and erase, on locked and unlocked blocks
  task automatic test_program_erase();
    write_cmd(CMD_PROG_SETUP);
    write_word(16'h0010, 16'h1234);
    read_word(16'h0010);
    write_cmd(CMD_CLEAR_STATUS);
    write_cmd(CMD_LOCK_SETUP);
    write_word(16'h0ABC, {8'h00, CMD_CONFIRM});
    write_cmd(CMD_PROG_SETUP);
    read_word(16'h0010);
    write_word(16'h0010, 16'h1234);
    write_cmd(CMD_READ_ARRAY);
    read_word(16'h0010);
    write_cmd(CMD_ERASE_SETUP);
    write_word(16'h0005, {8'hFF, CMD_CONFIRM});
    write_cmd(CMD_ERASE_SETUP);
    write_word(16'hF000, {8'h55, CMD_CONFIRM});
    write_cmd(CMD_READ_ARRAY);
    read_word(16'h0010);
  endtask

  // Bad confirms and relocking
  task automatic test_lock_errors();
    write_cmd(CMD_ERASE_SETUP);
    write_word(16'h0000, 16'h0000);
    write_cmd(CMD_LOCK_SETUP);
    write_word(16'h0001, 16'h0033);
    write_cmd(CMD_LOCK_SETUP);
    write_word(16'h0002, {8'h00, CMD_LOCK_BLOCK});
    read_word(16'h0002);
  endtask

  // Mostly well-formed command sequences with random content, some noise
  task automatic test_random_traffic(int unsigned count);
    logic [7:0]  mode_cmds [4];
    int unsigned sent;
    int unsigned pick;
    mode_cmds = '{CMD_READ_ARRAY, CMD_READ_ID, CMD_READ_STATUS, CMD_CLEAR_STATUS};
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(99);
      if (pick < 30) begin
        read_word(pick_address());
        sent += 1;
      end else if (pick < 42) begin
        write_cmd(mode_cmds[$urandom_range(3)]);
        sent += 1;
      end else if (pick < 66) begin
        write_cmd(CMD_PROG_SETUP);
        if ($urandom_range(3) == 0) read_word(pick_address());
        write_word(pick_address(), DATA_W'($urandom));
        sent += 3;
      end else if (pick < 70) begin
        write_cmd(CMD_ERASE_SETUP);
        write_word(pick_address(), {8'($urandom), CMD_CONFIRM});
        sent += 2;
      end else if (pick < 80) begin
        write_cmd(CMD_LOCK_SETUP);
        case ($urandom_range(2))
          0:       write_word(pick_address(), {8'($urandom), CMD_CONFIRM});
          1:       write_word(pick_address(), {8'($urandom), CMD_LOCK_BLOCK});
          default: write_word(pick_address(), DATA_W'($urandom));
        endcase
        sent += 2;
      end else if (pick < 84) begin
        write_cmd(CMD_ERASE_SETUP);
        write_word(pick_address(), DATA_W'($urandom));
        sent += 2;
      end else begin
        write_word(DATA_W'($urandom), DATA_W'($urandom));
        sent += 1;
      end
      // now and then hold off until the pipe is empty
      if ($urandom_range(39) == 0) settle();
    end
    settle();
  endtask

  initial begin
    shadow_reset();
    send_idle_pct = 28;
    recv_idle_pct = 70;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    write_reg(REG_MFR, DATA_W'($urandom));
    write_reg(REG_DEV, DATA_W'($urandom));
    test_read_modes();
    test_program_erase();
    test_lock_errors();
    settle();

    write_reg(REG_MFR, '0);
    write_reg(REG_DEV, '1);
    test_random_traffic(150);

    send_idle_pct = 70;
    recv_idle_pct = 28;
    write_reg(REG_MFR, '1);
    write_reg(REG_DEV, '0);
    test_random_traffic(150);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(REG_MFR, DATA_W'($urandom));
    write_reg(REG_DEV, DATA_W'($urandom));
    test_random_traffic(150);

    repeat (ERASE_SETTLE) @(posedge clk_i);
    if (mismatches == 0 && due_responses.size() == 0) begin
      $display("nor_flash_command_interface_top regression: pass");
    end else begin
      $display("nor_flash_command_interface_top regression: fail");
    end
    $finish;
  end

endmodule
